FILE: hdl/edc_pkg.sv
// Shared widths, types and helpers for the elastic disc collision datapath.
`default_nettype none
package edc_pkg;
  localparam int P_W    = 18;
  localparam int V_W    = 16;
  localparam int M_W    = 17;
  localparam int D_W    = P_W + 1;
  localparam int DV_W   = V_W + 1;
  localparam int SQ_W   = 2 * P_W;
  localparam int PD_W   = DV_W + D_W;
  localparam int DOT_W  = PD_W + 1;
  localparam int D2_W   = SQ_W + 1;
  localparam int AD_W   = P_W;
  localparam int MS_W   = M_W + 1;
  localparam int PX_W   = DOT_W + AD_W;
  localparam int DEN_W  = MS_W + D2_W;
  localparam int NUM_W  = PX_W + MS_W;
  localparam int Q_W    = 19;
  localparam int LANES  = 4;
  localparam int SUM_W  = Q_W + 3;

  typedef logic signed [V_W-1:0]    vel_t;
  typedef logic [DEN_W-1:0]         den_t;
  typedef logic [LANES-1:0][NUM_W-1:0] num_vec_t;
  typedef logic [LANES-1:0][Q_W-1:0]   quo_vec_t;

  // Lane order everywhere: a.x, a.y, b.x, b.y.
  typedef struct packed {
    logic [LANES-1:0][V_W-1:0] vel;
    logic [1:0]                neg;
    logic                      pass;
    logic                      coin;
  } side_t;

  function automatic vel_t sat_vel(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(2 ** (V_W - 1) - 1);
    lo = -SUM_W'(2 ** (V_W - 1));
    if (v > hi) begin
      sat_vel = hi[V_W-1:0];
    end else if (v < lo) begin
      sat_vel = lo[V_W-1:0];
    end else begin
      sat_vel = v[V_W-1:0];
    end
  endfunction
endpackage
`default_nettype wire

FILE: hdl/edc_if.sv
// Request and result channel interfaces of the disc collision block.
`default_nettype none
interface edc_in_if;
  import edc_pkg::*;
  logic           valid;
  logic           ready;
  logic [P_W-1:0] a_pos_x;
  logic [P_W-1:0] a_pos_y;
  vel_t           a_vel_x;
  vel_t           a_vel_y;
  logic [M_W-1:0] a_mass;
  logic [P_W-1:0] b_pos_x;
  logic [P_W-1:0] b_pos_y;
  vel_t           b_vel_x;
  vel_t           b_vel_y;
  logic [M_W-1:0] b_mass;
  modport source (output valid, a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_mass,
                  b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_mass, input ready);
  modport sink (input valid, a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_mass,
                b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_mass, output ready);
endinterface

interface edc_out_if;
  import edc_pkg::*;
  logic valid;
  logic ready;
  vel_t a_new_vel_x;
  vel_t a_new_vel_y;
  vel_t b_new_vel_x;
  vel_t b_new_vel_y;
  logic coincident;
  modport source (output valid, a_new_vel_x, a_new_vel_y, b_new_vel_x, b_new_vel_y,
                  coincident, input ready);
  modport sink (input valid, a_new_vel_x, a_new_vel_y, b_new_vel_x, b_new_vel_y,
                coincident, output ready);
endinterface
`default_nettype wire

FILE: hdl/elastic_disc_collision.sv
// Top level of the two-disc elastic collision response pipeline.
//
//   channel  | dir | contents
//   ---------+-----+------------------------------------------------------
//   in_ch    | in  | both discs: positions Q10.8, velocities Q8.8, masses
//   out_ch   | out | both new velocities Q8.8 (saturated), coincident flag
//
// One request enters per cycle unless the output stalls; each result passes
// five arithmetic stages, nineteen divider stages (one quotient bit each), and
// the output register. The 19-bit change magnitude sets the divider depth.
// Reset (synchronous, rst) clears all valid bits; no payload is reset.
// The whole pipeline holds while a result waits unaccepted; nothing is lost.
`default_nettype none
module elastic_disc_collision (
  input  logic       clk,
  input  logic       rst,
  edc_in_if.sink     in_ch,
  edc_out_if.source  out_ch
);
  import edc_pkg::*;

  logic     en;
  logic     f_valid;
  num_vec_t f_num;
  den_t     f_den;
  side_t    f_side;
  num_vec_t d_rem;
  quo_vec_t d_quo;
  den_t     d_den;
  side_t    sp  [Q_W];
  logic [Q_W-1:0] spv;

  assign en = !out_ch.valid || out_ch.ready;

  edc_front u_front (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_ch (in_ch),
    .valid (f_valid),
    .num   (f_num),
    .den   (f_den),
    .side  (f_side)
  );

  edc_div u_div (
    .clk     (clk),
    .en      (en),
    .num_in  (f_num),
    .den_in  (f_den),
    .rem_out (d_rem),
    .quo_out (d_quo),
    .den_out (d_den)
  );

  // Side data travels alongside the divider stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      spv <= '0;
    end else if (en) begin
      spv <= {spv[Q_W-2:0], f_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp[0] <= f_side;
      for (int k = 1; k < Q_W; k++) begin
        sp[k] <= sp[k-1];
      end
    end
  end

  edc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (spv[Q_W-1]),
    .side     (sp[Q_W-1]),
    .quo      (d_quo),
    .rem      (d_rem),
    .den      (d_den),
    .out_ch   (out_ch)
  );
endmodule
`default_nettype wire

FILE: hdl/edc_front.sv
// Five-stage front end: differences, products, dot product, numerators, denominator.
`default_nettype none
module edc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  edc_in_if.sink          in_ch,
  output logic            valid,
  output edc_pkg::num_vec_t num,
  output edc_pkg::den_t   den,
  output edc_pkg::side_t  side
);
  import edc_pkg::*;

  logic [3:0] v;

  // Stage 1
  logic signed [D_W-1:0]  s1_dx, s1_dy;
  logic signed [DV_W-1:0] s1_dvx, s1_dvy;
  logic [M_W-1:0]         s1_am, s1_bm;
  logic [LANES-1:0][V_W-1:0] s1_vel;
  // Stage 2
  logic [SQ_W-1:0]        s2_sqx, s2_sqy;
  logic signed [PD_W-1:0] s2_pdx, s2_pdy;
  logic signed [D_W-1:0]  s2_dx, s2_dy;
  logic [M_W-1:0]         s2_am, s2_bm;
  logic [LANES-1:0][V_W-1:0] s2_vel;
  // Stage 3
  logic [D2_W-1:0]  s3_d2;
  logic [MS_W-1:0]  s3_msum;
  logic [DOT_W-1:0] s3_adot;
  logic [AD_W-1:0]  s3_adx, s3_ady;
  logic [MS_W-1:0]  s3_m2a, s3_m2b;
  side_t            s3_side;
  // Stage 4
  logic [PX_W-1:0]  s4_px, s4_py;
  logic [MS_W-1:0]  s4_m2a, s4_m2b;
  logic [DEN_W-1:0] s4_den;
  side_t            s4_side;

  logic signed [2*D_W-1:0] sqx_full, sqy_full;
  logic signed [PD_W-1:0]  pdx, pdy;
  logic signed [DOT_W-1:0] dot;
  logic [D2_W-1:0]         d2;
  logic [MS_W-1:0]         msum;
  logic signed [D_W-1:0]   adx_full, ady_full;
  logic signed [DOT_W-1:0] adot_full;

  assign in_ch.ready = en;

  assign sqx_full = s1_dx * s1_dx;
  assign sqy_full = s1_dy * s1_dy;
  assign pdx = s1_dvx * s1_dx;
  assign pdy = s1_dvy * s1_dy;

  assign dot       = DOT_W'(s2_pdx) + DOT_W'(s2_pdy);
  assign d2        = D2_W'(s2_sqx) + D2_W'(s2_sqy);
  assign msum      = MS_W'(s2_am) + MS_W'(s2_bm);
  assign adot_full = dot[DOT_W-1] ? -dot : dot;
  assign adx_full  = s2_dx[D_W-1] ? -s2_dx : s2_dx;
  assign ady_full  = s2_dy[D_W-1] ? -s2_dy : s2_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v     <= '0;
      valid <= 1'b0;
    end else if (en) begin
      v     <= {v[2:0], in_ch.valid};
      valid <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx  <= $signed({1'b0, in_ch.b_pos_x}) - $signed({1'b0, in_ch.a_pos_x});
      s1_dy  <= $signed({1'b0, in_ch.b_pos_y}) - $signed({1'b0, in_ch.a_pos_y});
      s1_dvx <= DV_W'(in_ch.b_vel_x) - DV_W'(in_ch.a_vel_x);
      s1_dvy <= DV_W'(in_ch.b_vel_y) - DV_W'(in_ch.a_vel_y);
      s1_am  <= in_ch.a_mass;
      s1_bm  <= in_ch.b_mass;
      s1_vel <= {in_ch.b_vel_y, in_ch.b_vel_x, in_ch.a_vel_y, in_ch.a_vel_x};

      s2_sqx <= sqx_full[SQ_W-1:0];
      s2_sqy <= sqy_full[SQ_W-1:0];
      s2_pdx <= pdx;
      s2_pdy <= pdy;
      s2_dx  <= s1_dx;
      s2_dy  <= s1_dy;
      s2_am  <= s1_am;
      s2_bm  <= s1_bm;
      s2_vel <= s1_vel;

      s3_d2        <= d2;
      s3_msum      <= msum;
      s3_adot      <= adot_full;
      s3_adx       <= adx_full[AD_W-1:0];
      s3_ady       <= ady_full[AD_W-1:0];
      s3_m2a       <= {s2_am, 1'b0};
      s3_m2b       <= {s2_bm, 1'b0};
      s3_side.vel  <= s2_vel;
      // The change of a component is negative when the dot product and that
      // component of the offset have opposite signs.
      s3_side.neg  <= {dot[DOT_W-1] ^ s2_dy[D_W-1], dot[DOT_W-1] ^ s2_dx[D_W-1]};
      s3_side.coin <= (d2 == '0);
      s3_side.pass <= (d2 == '0) || (msum == '0);

      s4_px   <= s3_adot * s3_adx;
      s4_py   <= s3_adot * s3_ady;
      s4_den  <= s3_msum * s3_d2;
      s4_m2a  <= s3_m2a;
      s4_m2b  <= s3_m2b;
      s4_side <= s3_side;

      num[0] <= s4_px * s4_m2b;
      num[1] <= s4_py * s4_m2b;
      num[2] <= s4_px * s4_m2a;
      num[3] <= s4_py * s4_m2a;
      den    <= s4_den;
      side   <= s4_side;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/edc_div.sv
// Pipelined restoring divider, one quotient bit per stage, four lanes sharing a divisor.
`default_nettype none
module edc_div (
  input  logic               clk,
  input  logic               en,
  input  edc_pkg::num_vec_t  num_in,
  input  edc_pkg::den_t      den_in,
  output edc_pkg::num_vec_t  rem_out,
  output edc_pkg::quo_vec_t  quo_out,
  output edc_pkg::den_t      den_out
);
  import edc_pkg::*;
  localparam int RW = DEN_W + Q_W;

  num_vec_t rem [Q_W];
  quo_vec_t quo [Q_W];
  den_t     dsr [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_st
    localparam int B = Q_W - 1 - k;
    num_vec_t        r_prev;
    quo_vec_t        q_prev;
    den_t            d_prev;
    logic [RW-1:0]   shifted;
    num_vec_t        r_next;
    quo_vec_t        q_next;

    if (k == 0) begin : g_first
      assign r_prev = num_in;
      assign q_prev = '0;
      assign d_prev = den_in;
    end else begin : g_rest
      assign r_prev = rem[k-1];
      assign q_prev = quo[k-1];
      assign d_prev = dsr[k-1];
    end

    assign shifted = RW'(d_prev) << B;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        r_next[l] = r_prev[l];
        q_next[l] = q_prev[l];
        if (RW'(r_prev[l]) >= shifted) begin
          r_next[l]    = r_prev[l] - shifted[NUM_W-1:0];
          q_next[l][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= r_next;
        quo[k] <= q_next;
        dsr[k] <= d_prev;
      end
    end
  end

  assign rem_out = rem[Q_W-1];
  assign quo_out = quo[Q_W-1];
  assign den_out = dsr[Q_W-1];
endmodule
`default_nettype wire

FILE: hdl/edc_back.sv
// Output stage: round the quotients, apply signs, add to velocities and saturate.
`default_nettype none
module edc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid_in,
  input  edc_pkg::side_t    side,
  input  edc_pkg::quo_vec_t quo,
  input  edc_pkg::num_vec_t rem,
  input  edc_pkg::den_t     den,
  edc_out_if.source         out_ch
);
  import edc_pkg::*;

  logic [LANES-1:0][V_W-1:0] res;

  always_comb begin
    logic              rnd;
    logic [Q_W:0]      ch;
    logic signed [SUM_W-1:0] delta;
    logic signed [SUM_W-1:0] sum;
    for (int l = 0; l < LANES; l++) begin
      // Half or more of the divisor left over rounds the magnitude up.
      rnd   = ({rem[l], 1'b0} >= (NUM_W + 1)'(den));
      ch    = (Q_W + 1)'(quo[l]) + (Q_W + 1)'(rnd);
      delta = $signed(SUM_W'(ch));
      // The first disc gains the change, the second loses it.
      if (side.neg[l % 2] == (l >= 2)) begin
        sum = SUM_W'($signed(side.vel[l])) + delta;
      end else begin
        sum = SUM_W'($signed(side.vel[l])) - delta;
      end
      res[l] = side.pass ? side.vel[l] : sat_vel(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.a_new_vel_x <= res[0];
      out_ch.a_new_vel_y <= res[1];
      out_ch.b_new_vel_x <= res[2];
      out_ch.b_new_vel_y <= res[3];
      out_ch.coincident  <= side.coin;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/edc_checker.sv
// Port-level checks for the disc collision block, bound to the top level.
`default_nettype none
module edc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [64:0] out_bits
);
  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("request ready does not track the output register");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_bits))
    else $error("stalled result changed or vanished");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("result shown right after reset");

  a_result_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown(out_bits))
    else $error("result carries unknown bits");
endmodule

bind elastic_disc_collision edc_checker u_edc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_bits  ({out_ch.a_new_vel_x, out_ch.a_new_vel_y, out_ch.b_new_vel_x,
               out_ch.b_new_vel_y, out_ch.coincident})
);
`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the elastic disc collision block.
module tb;
  import edc_pkg::*;

  typedef struct packed {
    logic [P_W-1:0] a_pos_x;
    logic [P_W-1:0] a_pos_y;
    vel_t           a_vel_x;
    vel_t           a_vel_y;
    logic [M_W-1:0] a_mass;
    logic [P_W-1:0] b_pos_x;
    logic [P_W-1:0] b_pos_y;
    vel_t           b_vel_x;
    vel_t           b_vel_y;
    logic [M_W-1:0] b_mass;
  } disc_pair_t;

  typedef struct packed {
    vel_t a_vx;
    vel_t a_vy;
    vel_t b_vx;
    vel_t b_vy;
    logic coin;
  } bounce_t;

  typedef struct {
    disc_pair_t pair;
    logic       typed;
    bounce_t    result;
  } stim_row_t;

  localparam int NUM_RANDOM = 740;
  localparam int HOLD_OFF_CYCLES = 90;

  logic clk;
  logic rst;
  edc_in_if  in_ch();
  edc_out_if out_ch();

  elastic_disc_collision DUT (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  bounce_t   bounce_q[$];
  int        fail_count;
  int        result_count;
  logic      sender_done;
  logic      row_typed;
  bounce_t   row_result;
  stim_row_t stim_table[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [127:0] magnitude(input longint v);
    magnitude = v < 0 ? 128'(-v) : 128'(v);
  endfunction

  // Rounded 2*m_other*dot*dc / (msum*d2), ties away from zero.
  function automatic longint vel_change(input longint dot, input longint dc,
                                        input longint m_other, input longint msum,
                                        input longint d2);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    logic [127:0] r;
    num = magnitude(dot) * magnitude(dc) * 128'(2 * m_other);
    den = 128'(msum) * 128'(d2);
    q = num / den;
    r = num % den;
    if (r >= den - r) q = q + 1;
    vel_change = ((dot < 0) != (dc < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic vel_t clamp_vel(input longint v);
    if (v > 32767) clamp_vel = 16'sh7fff;
    else if (v < -32768) clamp_vel = 16'sh8000;
    else clamp_vel = vel_t'(v);
  endfunction

  function automatic bounce_t predict_bounce(input disc_pair_t p);
    longint dx, dy, d2, msum, dot;
    longint avx, avy, bvx, bvy, am, bm;
    bounce_t res;
    avx = p.a_vel_x;
    avy = p.a_vel_y;
    bvx = p.b_vel_x;
    bvy = p.b_vel_y;
    am = p.a_mass;
    bm = p.b_mass;
    dx = longint'(p.b_pos_x) - longint'(p.a_pos_x);
    dy = longint'(p.b_pos_y) - longint'(p.a_pos_y);
    d2 = dx * dx + dy * dy;
    msum = am + bm;
    res.a_vx = clamp_vel(avx);
    res.a_vy = clamp_vel(avy);
    res.b_vx = clamp_vel(bvx);
    res.b_vy = clamp_vel(bvy);
    if (d2 != 0 && msum != 0) begin
      dot = (bvx - avx) * dx + (bvy - avy) * dy;
      res.a_vx = clamp_vel(avx + vel_change(dot, dx, bm, msum, d2));
      res.a_vy = clamp_vel(avy + vel_change(dot, dy, bm, msum, d2));
      res.b_vx = clamp_vel(bvx - vel_change(dot, dx, am, msum, d2));
      res.b_vy = clamp_vel(bvy - vel_change(dot, dy, am, msum, d2));
    end
    res.coin = (d2 == 0);
    return res;
  endfunction

  function automatic disc_pair_t make_pair(input logic [P_W-1:0] ax, input logic [P_W-1:0] ay,
                                           input int avx, input int avy,
                                           input logic [M_W-1:0] am,
                                           input logic [P_W-1:0] bx, input logic [P_W-1:0] by,
                                           input int bvx, input int bvy,
                                           input logic [M_W-1:0] bm);
    disc_pair_t p;
    p.a_pos_x = ax;
    p.a_pos_y = ay;
    p.a_vel_x = vel_t'(avx);
    p.a_vel_y = vel_t'(avy);
    p.a_mass = am;
    p.b_pos_x = bx;
    p.b_pos_y = by;
    p.b_vel_x = vel_t'(bvx);
    p.b_vel_y = vel_t'(bvy);
    p.b_mass = bm;
    return p;
  endfunction

  function automatic logic [M_W-1:0] random_mass();
    case ($urandom_range(0, 3))
      0: random_mass = M_W'($urandom_range(1, 16));
      1: random_mass = M_W'($urandom_range(1, 1000));
      2: random_mass = M_W'($urandom_range(100000, 131071));
      default: random_mass = M_W'($urandom_range(1, 131071));
    endcase
  endfunction

  // Mostly nearby discs as a broad phase gives, plus coincident and full-range pairs.
  function automatic disc_pair_t random_pair();
    disc_pair_t p;
    int spread;
    p.a_pos_x = P_W'($urandom);
    p.a_pos_y = P_W'($urandom);
    p.a_vel_x = V_W'($urandom);
    p.a_vel_y = V_W'($urandom);
    p.b_vel_x = V_W'($urandom);
    p.b_vel_y = V_W'($urandom);
    p.a_mass = random_mass();
    p.b_mass = random_mass();
    case ($urandom_range(0, 9))
      0, 1: begin
        p.b_pos_x = P_W'($urandom);
        p.b_pos_y = P_W'($urandom);
      end
      2: begin
        p.b_pos_x = p.a_pos_x;
        p.b_pos_y = p.a_pos_y;
      end
      default: begin
        spread = 1 << $urandom_range(0, 14);
        p.b_pos_x = p.a_pos_x + P_W'($urandom_range(0, 2 * spread) - spread);
        p.b_pos_y = p.a_pos_y + P_W'($urandom_range(0, 2 * spread) - spread);
        if ($urandom_range(0, 1)) begin
          p.a_vel_x = V_W'($urandom_range(0, 4095) - 2048);
          p.a_vel_y = V_W'($urandom_range(0, 4095) - 2048);
          p.b_vel_x = V_W'($urandom_range(0, 4095) - 2048);
          p.b_vel_y = V_W'($urandom_range(0, 4095) - 2048);
        end
      end
    endcase
    return p;
  endfunction

  function automatic bounce_t unchanged(input disc_pair_t p);
    bounce_t res;
    res.a_vx = p.a_vel_x;
    res.a_vy = p.a_vel_y;
    res.b_vx = p.b_vel_x;
    res.b_vy = p.b_vel_y;
    res.coin = 1'b1;
    return res;
  endfunction

  task automatic add_row(input disc_pair_t p, input logic typed, input bounce_t res);
    stim_row_t row;
    row.pair = p;
    row.typed = typed;
    row.result = res;
    stim_table = {stim_table, row};
  endtask

  task automatic build_table();
    disc_pair_t p;
    bounce_t none;
    none = '0;
    // Coincident centres pass velocities through, at the corners and inside the field.
    p = make_pair(0, 0, 0, 0, 1, 0, 0, 0, 0, 1);
    add_row(p, 1'b1, unchanged(p));
    p = make_pair(18'h3ffff, 18'h3ffff, -32768, 32767, 131071,
                  18'h3ffff, 18'h3ffff, 32767, -32768, 131071);
    add_row(p, 1'b1, unchanged(p));
    p = make_pair(12345, 200, 256, -256, 7, 12345, 200, -512, 1000, 9);
    add_row(p, 1'b1, unchanged(p));
    // Equal masses head on along x swap velocities.
    p = make_pair(0, 0, 256, 0, 5, 256, 0, -256, 0, 5);
    add_row(p, 1'b1, '{a_vx: -256, a_vy: 0, b_vx: 256, b_vy: 0, coin: 1'b0});
    // Separating discs along y: the formula still applies.
    add_row(make_pair(100, 100, 0, -300, 3, 100, 900, 0, 300, 4), 1'b0, none);
    // Opposite corners, extreme velocities, extreme masses: saturation.
    add_row(make_pair(0, 0, 32767, 32767, 1, 18'h3ffff, 18'h3ffff, -32768, -32768, 131071),
            1'b0, none);
    add_row(make_pair(18'h3ffff, 0, -32768, 32767, 131071, 0, 18'h3ffff, 32767, -32768, 1),
            1'b0, none);
    add_row(make_pair(0, 18'h3ffff, 32767, -32768, 131071, 18'h3ffff, 0, -32768, 32767,
                      131071), 1'b0, none);
    // Unit distance, diagonal, and tie-prone small values.
    add_row(make_pair(1000, 1000, 1, 1, 1, 1001, 1000, -1, -1, 2), 1'b0, none);
    add_row(make_pair(1000, 1000, 3, 0, 1, 1001, 1001, 0, 0, 1), 1'b0, none);
    add_row(make_pair(5, 7, 128, 0, 2, 6, 7, 0, 0, 2), 1'b0, none);
    add_row(make_pair(40000, 9000, 0, 0, 131071, 40001, 9000, 0, 0, 131071), 1'b0, none);
    add_row(make_pair(200, 300, -100, 50, 65536, 180, 310, 70, -20, 1), 1'b0, none);
    add_row(make_pair(77, 77, 32767, 0, 131071, 78, 77, -32768, 0, 131071), 1'b0, none);
  endtask

  task automatic offer(input disc_pair_t p, input logic typed, input bounce_t res);
    in_ch.valid <= 1'b1;
    in_ch.a_pos_x <= p.a_pos_x;
    in_ch.a_pos_y <= p.a_pos_y;
    in_ch.a_vel_x <= p.a_vel_x;
    in_ch.a_vel_y <= p.a_vel_y;
    in_ch.a_mass <= p.a_mass;
    in_ch.b_pos_x <= p.b_pos_x;
    in_ch.b_pos_y <= p.b_pos_y;
    in_ch.b_vel_x <= p.b_vel_x;
    in_ch.b_vel_y <= p.b_vel_y;
    in_ch.b_mass <= p.b_mass;
    row_typed <= typed;
    row_result <= res;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Sender: gaps enabled in some stretches only, so back-to-back traffic happens too.
  initial begin
    int gap;
    logic gaps_on;
    bounce_t none;
    none = '0;
    gaps_on = 1'b0;
    sender_done = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.a_pos_x = '0;
    in_ch.a_pos_y = '0;
    in_ch.a_vel_x = '0;
    in_ch.a_vel_y = '0;
    in_ch.a_mass = 1;
    in_ch.b_pos_x = '0;
    in_ch.b_pos_y = '0;
    in_ch.b_vel_x = '0;
    in_ch.b_vel_y = '0;
    in_ch.b_mass = 1;
    row_typed = 1'b0;
    row_result = '0;
    build_table();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (stim_table[i]) begin
      offer(stim_table[i].pair, stim_table[i].typed, stim_table[i].result);
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 60 == 0) gaps_on = $urandom_range(0, 2) != 0;
      if (i == 400) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (bounce_q.size() != 0) @(negedge clk);
      end
      gap = gaps_on ? $urandom_range(0, 13) : 0;
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      offer(random_pair(), 1'b0, none);
    end
    in_ch.valid <= 1'b0;
    sender_done = 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off while requests keep coming.
  initial begin
    int stall;
    logic stalls_on;
    logic held;
    held = 1'b0;
    stalls_on = 1'b0;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (1) begin
      if (result_count % 50 == 0) stalls_on = $urandom_range(0, 2) != 0;
      if (!held && result_count >= 150) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        for (int c = 0; c < HOLD_OFF_CYCLES; c++) @(negedge clk);
      end
      stall = stalls_on ? $urandom_range(0, 13) : 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  task automatic compare_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name,
               $signed(exp_v), $signed(act_v));
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    bounce_t want;
    disc_pair_t p;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        p = make_pair(in_ch.a_pos_x, in_ch.a_pos_y, in_ch.a_vel_x, in_ch.a_vel_y,
                      in_ch.a_mass, in_ch.b_pos_x, in_ch.b_pos_y, in_ch.b_vel_x,
                      in_ch.b_vel_y, in_ch.b_mass);
        bounce_q = {bounce_q, (row_typed ? row_result : predict_bounce(p))};
      end
      if (out_ch.valid && out_ch.ready) begin
        result_count++;
        if (bounce_q.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %h %h %h %h %b", $time,
                   out_ch.a_new_vel_x, out_ch.a_new_vel_y, out_ch.b_new_vel_x,
                   out_ch.b_new_vel_y, out_ch.coincident);
          fail_count++;
        end else begin
          want = bounce_q.pop_front();
          compare_field("a_new_vel_x", want.a_vx, out_ch.a_new_vel_x);
          compare_field("a_new_vel_y", want.a_vy, out_ch.a_new_vel_y);
          compare_field("b_new_vel_x", want.b_vx, out_ch.b_new_vel_x);
          compare_field("b_new_vel_y", want.b_vy, out_ch.b_new_vel_y);
          compare_field("coincident", 16'(want.coin), 16'(out_ch.coincident));
        end
      end
    end
  end

  initial begin
    fail_count = 0;
    result_count = 0;
    wait (sender_done === 1'b1);
    while (bounce_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && bounce_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
